### hdl/rrpts_pkg.sv
`default_nettype none
package rrpts_pkg;
  localparam int unsigned MaxSlots = 4;
  localparam int unsigned DefSlotCount = 4;
  localparam logic [31:0] PeriodReset = 32'd3600;
  localparam logic [31:0] PollReset = 32'd1;
  localparam logic [31:0] NoneWaitSecs = 32'd3600;

  typedef enum logic [1:0] {
    REQ_POLL    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_FORCE   = 2'd2,
    REQ_DISABLE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OUT_ACTIVATED = 3'd0,
    OUT_WAITING   = 3'd1,
    OUT_BUSY      = 3'd2,
    OUT_NONE      = 3'd3,
    OUT_ACK       = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    CFG_PERIOD0 = 3'd0,
    CFG_PERIOD1 = 3'd1,
    CFG_PERIOD2 = 3'd2,
    CFG_PERIOD3 = 3'd3,
    CFG_POLL    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_CMP,
    ST_NEXT,
    ST_FIN,
    ST_WR,
    ST_DONE
  } state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

### hdl/rrpts_div.sv
`default_nettype none
module rrpts_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rrpts_pkg::div_req_t req,
  output rrpts_pkg::div_rsp_t  rsp
);
  import rrpts_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 32'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !req.start || cnt_nxt == 6'd32) else $error("divider count");
  a_den_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |=> $stable(den_r)) else $error("divisor changed");
endmodule
`default_nettype wire

### hdl/round_robin_periodic_task_scheduler.sv
`default_nettype none
// A release, a disable, a refused force and a busy poll pass ST_RD and ST_DONE;
// an accepted force also passes ST_WR. A schedule poll walks the slots one at a
// time: ST_NEXT skips a disabled slot, others pass ST_EVAL, ST_DIV and ST_MUL
// if a division is needed, then ST_CMP; ST_FIN closes the poll. Throughput: one
// transaction at a time; busy is high from accept to out_valid. Reset (rst_n low,
// synchronous) restores control, config and slot state; the receiver cannot stall.
module round_robin_periodic_task_scheduler #(
  parameter int unsigned SLOT_COUNT = rrpts_pkg::DefSlotCount
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [1:0]  in_slot_id,
  input  wire logic [31:0] in_now_secs,
  input  wire logic        in_time_valid,
  input  wire logic        in_preempt_active,
  output logic             out_valid,
  output logic [2:0]       out_outcome,
  output logic [1:0]       out_chosen_slot,
  output logic [31:0]      out_wake_secs,
  output logic             out_accepted,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rrpts_pkg::*;

  localparam logic [1:0] LastSlot = 2'(SLOT_COUNT - 1);

  // per-slot timestamps live in one memory: {last_activation, alignment_base}
  logic [63:0] mem [MaxSlots];
  logic [63:0] rd_data_r;
  logic        mem_we;
  logic [1:0]  mem_addr;
  logic [63:0] mem_wdata;
  logic [MaxSlots-1:0] vld_r;
  logic        rd_vld_r;
  logic [63:0] rd_word;

  logic [31:0] period_r [MaxSlots];
  logic [31:0] poll_r;
  logic [MaxSlots-1:0] dis_r, dis_nxt, act_r, act_nxt;
  logic [1:0]  last_r, last_nxt;

  state_t      st_r, st_nxt;
  logic [1:0]  req_r, sid_r;
  logic [31:0] now_r;
  logic        tv_r, pre_r;

  logic [1:0]  idx_r, idx_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        have_r, have_nxt;
  logic [1:0]  best_r, best_nxt;
  logic [31:0] bwait_r, bwait_nxt;
  logic [31:0] b_r, b_nxt, l_r, l_nxt, p_r, p_nxt;
  logic [31:0] due_r, due_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        zero_r, zero_nxt;

  logic        ovld_nxt, acc_nxt;
  logic [2:0]  oc_nxt;
  logic [1:0]  ch_nxt;
  logic [31:0] wk_nxt;
  logic        ovld_r, acc_r;
  logic [2:0]  oc_r;
  logic [1:0]  ch_r;
  logic [31:0] wk_r;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [MaxSlots-1:0] live;
  logic        any_act;
  logic [1:0]  act_idx;
  logic [31:0] wt;

  rrpts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // lowest active, enabled slot
  always_comb begin
    live = act_r & ~dis_r;
    any_act = 1'b0;
    act_idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (live[i] && i < SLOT_COUNT) begin
        any_act = 1'b1;
        act_idx = 2'(i);
      end
    end
  end

  // memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  // entry valid bits: an entry not yet written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) vld_r[mem_addr] <= 1'b1;
      rd_vld_r <= vld_r[mem_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : 64'd0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxSlots; i++) period_r[i] <= PeriodReset;
      poll_r <= PollReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD0: period_r[0] <= cfg_data;
        CFG_PERIOD1: period_r[1] <= cfg_data;
        CFG_PERIOD2: period_r[2] <= cfg_data;
        CFG_PERIOD3: period_r[3] <= cfg_data;
        CFG_POLL:    poll_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // wait of the current slot from evaluated fields
  assign wt = zero_r ? 32'd0 : ((now_r >= due_r) ? 32'd0 : due_r - now_r);

  always_comb begin
    st_nxt = st_r;
    dis_nxt = dis_r;
    act_nxt = act_r;
    last_nxt = last_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    have_nxt = have_r;
    best_nxt = best_r;
    bwait_nxt = bwait_r;
    b_nxt = b_r;
    l_nxt = l_r;
    p_nxt = p_r;
    due_nxt = due_r;
    prod_nxt = prod_r;
    zero_nxt = zero_r;
    mem_we = 1'b0;
    mem_addr = idx_r;
    mem_wdata = {l_r, b_r};
    dreq = '0;
    ovld_nxt = 1'b0;
    oc_nxt = oc_r;
    ch_nxt = ch_r;
    wk_nxt = wk_r;
    acc_nxt = acc_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) st_nxt = ST_RD;
      end
      ST_RD: begin
        oc_nxt = OUT_ACK;
        ch_nxt = '0;
        wk_nxt = '0;
        acc_nxt = 1'b1;
        unique case (req_t'(req_r))
          REQ_POLL: begin
            if (any_act) begin
              oc_nxt = OUT_BUSY;
              ch_nxt = act_idx;
              wk_nxt = now_r + poll_r;
              st_nxt = ST_DONE;
            end else begin
              idx_nxt = (last_r == LastSlot) ? 2'd0 : last_r + 2'd1;
              step_nxt = '0;
              have_nxt = 1'b0;
              st_nxt = ST_NEXT;
            end
          end
          REQ_RELEASE: begin
            if (any_act) begin
              act_nxt[act_idx] = 1'b0;
              ch_nxt = act_idx;
            end
            st_nxt = ST_DONE;
          end
          REQ_FORCE: begin
            ch_nxt = sid_r;
            if (32'(sid_r) >= SLOT_COUNT || (act_r[sid_r] && !pre_r)) begin
              acc_nxt = 1'b0;
              st_nxt = ST_DONE;
            end else begin
              idx_nxt = sid_r;
              mem_addr = sid_r;
              st_nxt = ST_WR;
            end
          end
          REQ_DISABLE: begin
            ch_nxt = sid_r;
            if (32'(sid_r) < SLOT_COUNT) dis_nxt[sid_r] = 1'b1;
            st_nxt = ST_DONE;
          end
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_WR: begin
        // force clears last activation, an activation sets it to now; both keep base
        mem_we = 1'b1;
        mem_wdata = {32'd0, rd_word[31:0]};
        st_nxt = ST_DONE;
      end
      ST_NEXT: begin
        // read issued for idx_r; skip disabled slots
        if (step_r == 3'(SLOT_COUNT)) begin
          st_nxt = ST_FIN;
        end else if (dis_r[idx_r]) begin
          step_nxt = step_r + 3'd1;
          idx_nxt = (idx_r == LastSlot) ? 2'd0 : idx_r + 2'd1;
        end else begin
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        l_nxt = rd_word[63:32];
        b_nxt = rd_word[31:0];
        if (rd_word[31:0] == 32'd0 && tv_r) b_nxt = now_r;
        p_nxt = period_r[idx_r];
        // write back the base
        mem_we = 1'b1;
        mem_wdata = {l_nxt, b_nxt};
        zero_nxt = (l_nxt == 32'd0) || (l_nxt < b_nxt) || (l_nxt > now_r);
        if (zero_nxt) begin
          st_nxt = ST_CMP;
        end else if (b_nxt == 32'd0) begin
          due_nxt = l_nxt + p_nxt;
          st_nxt = ST_CMP;
        end else begin
          if (p_nxt == 32'd0) p_nxt = 32'd1;
          dreq.start = 1'b1;
          dreq.num = l_nxt - b_nxt;
          dreq.den = p_nxt;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // (quotient + 1) * period, kept to 32 bits
        if (drsp.done) begin
          prod_nxt = drsp.quo * p_r + p_r;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        due_nxt = b_r + prod_r;
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!have_r || wt < bwait_r) begin
          have_nxt = 1'b1;
          bwait_nxt = wt;
          best_nxt = idx_r;
        end
        step_nxt = step_r + 3'd1;
        idx_nxt = (idx_r == LastSlot) ? 2'd0 : idx_r + 2'd1;
        st_nxt = ST_NEXT;
      end
      ST_FIN: begin
        mem_addr = best_r;
        if (!have_r) begin
          oc_nxt = OUT_NONE;
          wk_nxt = now_r + NoneWaitSecs;
          st_nxt = ST_DONE;
        end else if (bwait_r != 32'd0) begin
          oc_nxt = OUT_WAITING;
          ch_nxt = best_r;
          wk_nxt = now_r + bwait_r + 32'd1;
          st_nxt = ST_DONE;
        end else begin
          oc_nxt = OUT_ACTIVATED;
          ch_nxt = best_r;
          wk_nxt = now_r;
          last_nxt = best_r;
          act_nxt[best_r] = 1'b1;
          idx_nxt = best_r;
          st_nxt = ST_WR;
          step_nxt = 3'd7;
        end
      end
      ST_DONE: begin
        ovld_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // activation write uses now instead of zero
    if (st_r == ST_WR && step_r == 3'd7) mem_wdata = {now_r, rd_word[31:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      dis_r <= '0;
      act_r <= '0;
      last_r <= LastSlot;
      ovld_r <= 1'b0;
      step_r <= '0;
      idx_r <= '0;
      have_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      dis_r <= dis_nxt;
      act_r <= act_nxt;
      last_r <= last_nxt;
      ovld_r <= ovld_nxt;
      step_r <= (st_r == ST_IDLE) ? 3'd0 : step_nxt;
      idx_r <= idx_nxt;
      have_r <= have_nxt;
    end
    if (st_r == ST_IDLE && start) begin
      req_r <= in_req_type;
      sid_r <= in_slot_id;
      now_r <= in_now_secs;
      tv_r <= in_time_valid;
      pre_r <= in_preempt_active;
    end
    best_r <= best_nxt;
    bwait_r <= bwait_nxt;
    b_r <= b_nxt;
    l_r <= l_nxt;
    p_r <= p_nxt;
    due_r <= due_nxt;
    prod_r <= prod_nxt;
    zero_r <= zero_nxt;
    oc_r <= oc_nxt;
    ch_r <= ch_nxt;
    wk_r <= wk_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = (st_r != ST_IDLE);
  assign out_valid = ovld_r;
  assign out_outcome = oc_r;
  assign out_chosen_slot = ch_r;
  assign out_wake_secs = wk_r;
  assign out_accepted = acc_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == ST_IDLE) else $error("result outside idle");
  a_activate_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_ACTIVATED |-> act_r[out_chosen_slot])
    else $error("activated slot not marked");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
endmodule
`default_nettype wire
